// ----- rtl/core/upper_bound_float_unit_defines.svh -----
// ============================================================================
// upper_bound_float_unit_defines.svh
// Assertion macros shared by the upper bound float unit RTL.
// ============================================================================
`ifndef UPPER_BOUND_FLOAT_UNIT_DEFINES_SVH
`define UPPER_BOUND_FLOAT_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held
`define UBFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubfu: same-cycle check failed");

// Next-cycle implication, ignored while reset is held
`define UBFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubfu: next-cycle check failed");

`endif

// ----- rtl/core/ubfu_pkg.sv -----
// ============================================================================
// ubfu_pkg
// Widths, command codes and pipeline stage types of the upper bound float unit.
// ============================================================================
`timescale 1ns / 1ps

package ubfu_pkg;

  localparam int MANT_W  = 32;
  localparam int EXP_W   = 32;
  localparam int HALF_W  = MANT_W / 2;
  localparam int SHIFT_W = $clog2(MANT_W);

  localparam logic [MANT_W-1:0] M_TOP = {1'b1, {(MANT_W-1){1'b0}}};
  localparam logic [EXP_W-1:0]  E_MIN = {1'b1, {(EXP_W-1){1'b0}}};
  localparam logic [EXP_W-1:0]  E_MAX = {1'b0, {(EXP_W-1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_CMP  = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_MUL  = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  // Stage 1: operands ordered by exponent, multiply operands prepared
  typedef struct packed {
    cmd_t                cmd;
    logic                x_zero;
    logic                y_zero;
    logic                x_lt;       // x exponent below y exponent
    logic                s_nz;       // smaller-exponent mantissa nonzero
    logic [MANT_W-1:0]   s_m;        // smaller-exponent mantissa
    logic [MANT_W-1:0]   s_dec;      // s_m - 1
    logic [MANT_W-1:0]   b_m;        // larger-exponent mantissa
    logic [EXP_W-1:0]    b_e;        // larger exponent
    logic                shift_big;  // difference >= MANT_W
    logic [SHIFT_W-1:0]  shift_amt;
    logic [EXP_W-1:0]    e_sum;
    logic                mul_under;
    logic                mul_over;
    logic                mul_pass;   // a half mantissa rounded up to 2^HALF_W
    logic [MANT_W-1:0]   pass_m;
    logic [HALF_W-1:0]   xh;
    logic [HALF_W-1:0]   yh;
  } s1_t;

  // Stage 2: shifted mantissas, product, exponent neighbors
  typedef struct packed {
    cmd_t                cmd;
    logic                x_zero;
    logic                y_zero;
    logic                x_lt;
    logic                s_nz;
    logic [MANT_W-1:0]   b_m;
    logic [MANT_W-1:0]   floor_m;    // floor shift of s_m
    logic [MANT_W-1:0]   ceil_base;  // ceil shift of s_m minus s_nz
    logic [EXP_W-1:0]    b_e;
    logic [EXP_W-1:0]    b_e_inc;
    logic                b_e_max;
    logic [EXP_W-1:0]    e_sum;
    logic [EXP_W-1:0]    e_sum_dec;
    logic                e_sum_min;
    logic                mul_under;
    logic                mul_over;
    logic                mul_pass;
    logic [MANT_W-1:0]   pass_m;
    logic [MANT_W-1:0]   prod;
  } s2_t;

endpackage

// ----- rtl/core/upper_bound_float_unit.sv -----
// ============================================================================
// upper_bound_float_unit
// Round-up bound arithmetic: compare, add and multiply on mantissa/exponent.
// ============================================================================
// Channel  | Direction | Handshake         | Beat contents
// in_      | input     | in_valid/in_stall | cmd, x mantissa/exponent, y m/e
// out_     | output    | out_valid/stall   | res mantissa/exponent, is_less, status
// cfg_     | input     | cfg_we            | check_overflow bit
//
// Three register stages: order/prepare, shift/multiply, add/normalize.
// One beat per cycle is sustained while out_stall is low, since every stage is
// registered; the 16x16 multiplier and 32-bit aligner share the middle stage.
// Reset empties the pipeline and sets check_overflow to 1.
// Each stage advances when the stage after it is empty or moving, so
// bubbles close up and a stall loses no beat.
`timescale 1ns / 1ps
`include "upper_bound_float_unit_defines.svh"

module upper_bound_float_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_cmd,
  input  logic [ubfu_pkg::MANT_W-1:0]        in_x_mantissa,
  input  logic signed [ubfu_pkg::EXP_W-1:0]  in_x_exponent,
  input  logic [ubfu_pkg::MANT_W-1:0]        in_y_mantissa,
  input  logic signed [ubfu_pkg::EXP_W-1:0]  in_y_exponent,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ubfu_pkg::MANT_W-1:0]        out_res_mantissa,
  output logic signed [ubfu_pkg::EXP_W-1:0]  out_res_exponent,
  output logic                               out_is_less,
  output logic                               out_status
);

  logic                           chk_r;
  logic                           s1_v_r;
  logic                           s2_v_r;
  logic                           out_v_r;
  ubfu_pkg::s1_t                  s1_nxt;
  ubfu_pkg::s1_t                  s1_r;
  ubfu_pkg::s2_t                  s2_nxt;
  ubfu_pkg::s2_t                  s2_r;
  logic                           en1;
  logic                           en2;
  logic                           en3;

  logic [ubfu_pkg::EXP_W-1:0]     kx;
  logic [ubfu_pkg::EXP_W-1:0]     ky;
  logic [ubfu_pkg::EXP_W:0]       d_xy;
  logic [ubfu_pkg::EXP_W:0]       d_yx;
  logic [ubfu_pkg::EXP_W-1:0]     diff;
  logic [ubfu_pkg::MANT_W-1:0]    xm_dec;
  logic [ubfu_pkg::MANT_W-1:0]    ym_dec;
  logic                           xh_ovf;
  logic                           yh_ovf;

  logic [ubfu_pkg::MANT_W:0]      add_sum;
  logic [ubfu_pkg::MANT_W-1:0]    res_m_nxt;
  logic [ubfu_pkg::EXP_W-1:0]     res_e_nxt;
  logic                           less_nxt;
  logic                           status_nxt;
  logic [ubfu_pkg::MANT_W-1:0]    res_m_r;
  logic [ubfu_pkg::EXP_W-1:0]     res_e_r;
  logic                           less_r;
  logic                           status_r;

  // Stage enables: a stage moves when its successor is empty or moving
  assign en3      = !out_v_r || !out_stall;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= 1'b1;
    end else if (cfg_we) begin
      chk_r <= cfg_wdata;
    end
  end

  // Stage 1: order operands by exponent, prepare multiply
  always_comb begin
    kx     = in_x_exponent ^ ubfu_pkg::E_MIN;
    ky     = in_y_exponent ^ ubfu_pkg::E_MIN;
    d_xy   = {1'b0, kx} - {1'b0, ky};
    d_yx   = {1'b0, ky} - {1'b0, kx};
    xm_dec = in_x_mantissa - ubfu_pkg::MANT_W'(1);
    ym_dec = in_y_mantissa - ubfu_pkg::MANT_W'(1);
    xh_ovf = &xm_dec[ubfu_pkg::MANT_W-1 -: ubfu_pkg::HALF_W];
    yh_ovf = &ym_dec[ubfu_pkg::MANT_W-1 -: ubfu_pkg::HALF_W];

    s1_nxt.cmd    = ubfu_pkg::cmd_t'(in_cmd);
    s1_nxt.x_zero = (in_x_mantissa == '0);
    s1_nxt.y_zero = (in_y_mantissa == '0);
    s1_nxt.x_lt   = d_xy[ubfu_pkg::EXP_W];
    diff          = s1_nxt.x_lt ? d_yx[ubfu_pkg::EXP_W-1:0] : d_xy[ubfu_pkg::EXP_W-1:0];
    s1_nxt.s_nz   = s1_nxt.x_lt ? !s1_nxt.x_zero : !s1_nxt.y_zero;
    s1_nxt.s_m    = s1_nxt.x_lt ? in_x_mantissa : in_y_mantissa;
    s1_nxt.s_dec  = s1_nxt.x_lt ? xm_dec : ym_dec;
    s1_nxt.b_m    = s1_nxt.x_lt ? in_y_mantissa : in_x_mantissa;
    s1_nxt.b_e    = s1_nxt.x_lt ? in_y_exponent : in_x_exponent;
    s1_nxt.shift_big = |diff[ubfu_pkg::EXP_W-1:ubfu_pkg::SHIFT_W];
    s1_nxt.shift_amt = diff[ubfu_pkg::SHIFT_W-1:0];

    s1_nxt.e_sum     = in_x_exponent + in_y_exponent;
    s1_nxt.mul_under = in_x_exponent[ubfu_pkg::EXP_W-1] && in_y_exponent[ubfu_pkg::EXP_W-1]
                    && !s1_nxt.e_sum[ubfu_pkg::EXP_W-1];
    s1_nxt.mul_over  = !in_x_exponent[ubfu_pkg::EXP_W-1] && !in_y_exponent[ubfu_pkg::EXP_W-1]
                    && s1_nxt.e_sum[ubfu_pkg::EXP_W-1];
    s1_nxt.mul_pass  = xh_ovf || yh_ovf;
    // x rounding up to 2^HALF_W takes precedence: result is y
    s1_nxt.pass_m    = xh_ovf ? in_y_mantissa : in_x_mantissa;
    s1_nxt.xh = xm_dec[ubfu_pkg::MANT_W-1 -: ubfu_pkg::HALF_W] + ubfu_pkg::HALF_W'(1);
    s1_nxt.yh = ym_dec[ubfu_pkg::MANT_W-1 -: ubfu_pkg::HALF_W] + ubfu_pkg::HALF_W'(1);
  end

  // Stage 2: shifts and product
  ubfu_shift_mul u_shift_mul (
    .s1 (s1_r),
    .s2 (s2_nxt)
  );

  // Stage 3: compare, add with carry renormalize, multiply normalize
  always_comb begin
    add_sum    = {1'b0, s2_r.b_m} + {1'b0, s2_r.ceil_base}
               + {{ubfu_pkg::MANT_W{1'b0}}, s2_r.s_nz};
    res_m_nxt  = '0;
    res_e_nxt  = '0;
    less_nxt   = 1'b0;
    status_nxt = 1'b0;
    unique case (s2_r.cmd)
      ubfu_pkg::CMD_CMP: begin
        priority if (s2_r.x_zero) begin
          less_nxt = 1'b1;
        end else if (s2_r.y_zero) begin
          less_nxt = 1'b0;
        end else if (s2_r.x_lt) begin
          less_nxt = s2_r.floor_m < s2_r.b_m;
        end else begin
          less_nxt = s2_r.floor_m > s2_r.b_m;
        end
      end
      ubfu_pkg::CMD_ADD: begin
        if (add_sum[ubfu_pkg::MANT_W]) begin
          if (chk_r && s2_r.b_e_max) begin
            status_nxt = 1'b1;
          end else begin
            res_m_nxt = {1'b1, add_sum[ubfu_pkg::MANT_W-1:1]};
            res_e_nxt = s2_r.b_e_inc;
          end
        end else begin
          res_m_nxt = add_sum[ubfu_pkg::MANT_W-1:0];
          res_e_nxt = s2_r.b_e;
        end
      end
      ubfu_pkg::CMD_MUL: begin
        priority if (s2_r.x_zero || s2_r.y_zero) begin
          res_m_nxt = '0;
        end else if (s2_r.mul_under) begin
          res_m_nxt = ubfu_pkg::M_TOP;
          res_e_nxt = ubfu_pkg::E_MIN;
        end else if (s2_r.mul_over && chk_r) begin
          status_nxt = 1'b1;
        end else if (s2_r.mul_pass) begin
          res_m_nxt = s2_r.pass_m;
          res_e_nxt = s2_r.e_sum;
        end else if (s2_r.prod[ubfu_pkg::MANT_W-1]) begin
          res_m_nxt = s2_r.prod;
          res_e_nxt = s2_r.e_sum;
        end else if (s2_r.e_sum_min) begin
          res_m_nxt = ubfu_pkg::M_TOP;
          res_e_nxt = s2_r.e_sum;
        end else begin
          res_m_nxt = {s2_r.prod[ubfu_pkg::MANT_W-2:0], 1'b0};
          res_e_nxt = s2_r.e_sum_dec;
        end
      end
      ubfu_pkg::CMD_RSVD: begin
        res_m_nxt = '0;
      end
    endcase
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= in_valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (en2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
    if (en3 && s2_v_r) begin
      res_m_r  <= res_m_nxt;
      res_e_r  <= res_e_nxt;
      less_r   <= less_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_res_mantissa = res_m_r;
  assign out_res_exponent = res_e_r;
  assign out_is_less      = less_r;
  assign out_status       = status_r;

  // Checks
  `UBFU_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, s1_v_r)
  `UBFU_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, s1_v_r && s2_v_r && out_v_r)
  `UBFU_ASSERT_NOW(a_ovf_zero_result, clk, rst_n, out_v_r && status_r, chk_r && res_m_r == '0 && res_e_r == '0 && !less_r)
  `UBFU_ASSERT_NOW(a_less_only_compare, clk, rst_n, out_v_r && less_r, !status_r && res_m_r == '0 && res_e_r == '0)

endmodule

// ----- rtl/core/ubfu_shift_mul.sv -----
// ============================================================================
// ubfu_shift_mul
// Middle stage logic: alignment shifts, half-width product, exponent +/- 1.
// ============================================================================
`timescale 1ns / 1ps

module ubfu_shift_mul (
  input  ubfu_pkg::s1_t s1,
  output ubfu_pkg::s2_t s2
);

  logic [ubfu_pkg::MANT_W-1:0] floor_sh;
  logic [ubfu_pkg::MANT_W-1:0] ceil_sh;

  // Alignment: floor shift for compare, ceil shift base for add
  assign floor_sh = s1.shift_big ? '0 : (s1.s_m >> s1.shift_amt);
  assign ceil_sh  = s1.shift_big ? '0 : (s1.s_dec >> s1.shift_amt);

  always_comb begin
    s2.cmd       = s1.cmd;
    s2.x_zero    = s1.x_zero;
    s2.y_zero    = s1.y_zero;
    s2.x_lt      = s1.x_lt;
    s2.s_nz      = s1.s_nz;
    s2.b_m       = s1.b_m;
    s2.floor_m   = floor_sh;
    // zero mantissa stays zero after a ceiling shift
    s2.ceil_base = s1.s_nz ? ceil_sh : '0;
    s2.b_e       = s1.b_e;
    s2.b_e_inc   = s1.b_e + ubfu_pkg::EXP_W'(1);
    s2.b_e_max   = (s1.b_e == ubfu_pkg::E_MAX);
    s2.e_sum     = s1.e_sum;
    s2.e_sum_dec = s1.e_sum - ubfu_pkg::EXP_W'(1);
    s2.e_sum_min = (s1.e_sum == ubfu_pkg::E_MIN);
    s2.mul_under = s1.mul_under;
    s2.mul_over  = s1.mul_over;
    s2.mul_pass  = s1.mul_pass;
    s2.pass_m    = s1.pass_m;
    s2.prod      = {{(ubfu_pkg::MANT_W-ubfu_pkg::HALF_W){1'b0}}, s1.xh}
                 * {{(ubfu_pkg::MANT_W-ubfu_pkg::HALF_W){1'b0}}, s1.yh};
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ============================================================================
// testbench
// Self-checking bench for upper_bound_float_unit: a built-in round-up
// predictor checks each compare, add and multiply result, in order, under
// random sender gaps and receiver stalls, with overflow checking on and off.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

  localparam int PIPE_LATENCY = 3;
  localparam int TAIL_CYCLES  = 8;

  // Block ports
  logic                              clk              = 1'b0;
  logic                              rst_n            = 1'b0;
  logic                              cfg_we           = 1'b0;
  logic                              cfg_wdata        = 1'b0;
  logic                              in_valid         = 1'b0;
  logic                              in_stall;
  ubfu_pkg::cmd_t                    in_cmd           = ubfu_pkg::CMD_CMP;
  logic [ubfu_pkg::MANT_W-1:0]       in_x_mantissa    = '0;
  logic signed [ubfu_pkg::EXP_W-1:0] in_x_exponent    = '0;
  logic [ubfu_pkg::MANT_W-1:0]       in_y_mantissa    = '0;
  logic signed [ubfu_pkg::EXP_W-1:0] in_y_exponent    = '0;
  logic                              out_valid;
  logic                              out_stall        = 1'b0;
  logic [ubfu_pkg::MANT_W-1:0]       out_res_mantissa;
  logic signed [ubfu_pkg::EXP_W-1:0] out_res_exponent;
  logic                              out_is_less;
  logic                              out_status;

  typedef struct packed {
    logic [ubfu_pkg::MANT_W-1:0]       mant;
    logic signed [ubfu_pkg::EXP_W-1:0] expo;
    logic                              less;
    logic                              status;
  } bound_result_t;

  bound_result_t bound_results_q[$];
  bit            overflow_checked = 1'b1;  // local copy of check_overflow
  int            fail_count       = 0;
  int            send_idle_pct    = 0;
  int            recv_stall_pct   = 0;

  upper_bound_float_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_x_mantissa    (in_x_mantissa),
    .in_x_exponent    (in_x_exponent),
    .in_y_mantissa    (in_y_mantissa),
    .in_y_exponent    (in_y_exponent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res_mantissa (out_res_mantissa),
    .out_res_exponent (out_res_exponent),
    .out_is_less      (out_is_less),
    .out_status       (out_status)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Round-up bound arithmetic
  // --------------------------------------------------------------------------
  function automatic logic [63:0] floor_shift(input logic [ubfu_pkg::MANT_W-1:0] v,
                                              input logic [ubfu_pkg::EXP_W-1:0] n);
    return (n < ubfu_pkg::MANT_W) ? 64'(v >> n) : 64'd0;
  endfunction

  function automatic logic [63:0] ceil_shift(input logic [ubfu_pkg::MANT_W-1:0] v,
                                             input logic [ubfu_pkg::EXP_W-1:0] n);
    if (v == '0) return 64'd0;
    return floor_shift(v - 1'b1, n) + 64'd1;
  endfunction

  function automatic bound_result_t bound_op_result(
      input ubfu_pkg::cmd_t                    c,
      input logic [ubfu_pkg::MANT_W-1:0]       xm,
      input logic signed [ubfu_pkg::EXP_W-1:0] xe,
      input logic [ubfu_pkg::MANT_W-1:0]       ym,
      input logic signed [ubfu_pkg::EXP_W-1:0] ye,
      input bit                                chk);
    bound_result_t               r;
    logic [ubfu_pkg::EXP_W-1:0]  kx, ky, diff, big_e, sum_e;
    logic [ubfu_pkg::MANT_W-1:0] big_m, small_m;
    logic [63:0]                 aligned, acc, xh, yh;
    logic                        x_neg, y_neg, s_neg;
    r  = '0;
    // biased keys order the exponents as unsigned numbers
    kx = xe ^ ubfu_pkg::E_MIN;
    ky = ye ^ ubfu_pkg::E_MIN;
    case (c)
      ubfu_pkg::CMD_CMP: begin
        if (xm == '0) r.less = 1'b1;
        else if (ym == '0) r.less = 1'b0;
        else if (kx < ky) r.less = floor_shift(xm, ky - kx) < 64'(ym);
        else r.less = floor_shift(ym, kx - ky) > 64'(xm);
      end
      ubfu_pkg::CMD_ADD: begin
        if (kx < ky) begin
          big_m = ym; big_e = ye; small_m = xm; diff = ky - kx;
        end else begin
          big_m = xm; big_e = xe; small_m = ym; diff = kx - ky;
        end
        aligned = ceil_shift(small_m, diff);
        acc     = 64'(big_m) + aligned;
        r.mant  = acc[ubfu_pkg::MANT_W-1:0];
        r.expo  = big_e;
        // carry out: renormalize and bump the exponent
        if (acc[ubfu_pkg::MANT_W]) begin
          r.mant = {1'b1, acc[ubfu_pkg::MANT_W-1:1]};
          if (chk && big_e == ubfu_pkg::E_MAX) begin
            r.status = 1'b1;
            r.mant   = '0;
            r.expo   = '0;
          end else begin
            r.expo = big_e + 1'b1;
          end
        end
      end
      ubfu_pkg::CMD_MUL: begin
        if (xm != '0 && ym != '0) begin
          sum_e = xe + ye;
          x_neg = xe[ubfu_pkg::EXP_W-1];
          y_neg = ye[ubfu_pkg::EXP_W-1];
          s_neg = sum_e[ubfu_pkg::EXP_W-1];
          if (x_neg && y_neg && !s_neg) begin
            // underflow clamps to the smallest bound
            r.expo = ubfu_pkg::E_MIN;
            r.mant = ubfu_pkg::M_TOP;
          end else if (!x_neg && !y_neg && s_neg && chk) begin
            r.status = 1'b1;
          end else begin
            r.expo = sum_e;
            xh     = ceil_shift(xm, ubfu_pkg::HALF_W);
            yh     = ceil_shift(ym, ubfu_pkg::HALF_W);
            if (xh[ubfu_pkg::HALF_W]) begin
              r.mant = ym;
            end else if (yh[ubfu_pkg::HALF_W]) begin
              r.mant = xm;
            end else begin
              acc    = xh * yh;
              r.mant = acc[ubfu_pkg::MANT_W-1:0];
              if (!r.mant[ubfu_pkg::MANT_W-1]) begin
                if (sum_e == ubfu_pkg::E_MIN) begin
                  r.mant = ubfu_pkg::M_TOP;
                end else begin
                  r.mant = r.mant << 1;
                  r.expo = sum_e - 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random operand generation
  // --------------------------------------------------------------------------
  function automatic logic [ubfu_pkg::MANT_W-1:0] rand_mantissa();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) return '0;
    if (k < 16) return {16'hFFFF, 16'($urandom)};      // half mantissa rounds to 2^16
    if (k < 28) return ubfu_pkg::MANT_W'($urandom);    // often unnormalized
    if (k < 34) return ubfu_pkg::M_TOP;
    if (k < 38) return '1;
    return {1'b1, 31'($urandom)};
  endfunction

  function automatic logic signed [ubfu_pkg::EXP_W-1:0] rand_exponent();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return int'($urandom_range(0, 80)) - 40;
    if (k < 55) return ubfu_pkg::E_MAX - $urandom_range(0, 3);
    if (k < 70) return ubfu_pkg::E_MIN + $urandom_range(0, 3);
    return ubfu_pkg::EXP_W'($urandom);
  endfunction

  // second exponent placed near the first, or near the exponent-sum limits
  function automatic logic signed [ubfu_pkg::EXP_W-1:0] rand_partner_exp(
      input logic signed [ubfu_pkg::EXP_W-1:0] xe, input bit for_mul);
    int k, off;
    k   = $urandom_range(0, 99);
    off = int'($urandom_range(0, 80)) - 40;
    if (for_mul) begin
      if (k < 30) return ubfu_pkg::E_MIN - xe + (off / 10);
      if (k < 45) return ubfu_pkg::E_MAX - xe + (off / 10);
      if (k < 60) return xe + off;
      return rand_exponent();
    end
    if (k < 45) return xe + off;
    if (k < 60) return xe;
    return rand_exponent();
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plumbing
  // --------------------------------------------------------------------------
  // Random receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic set_idle_phase(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // Present one beat, hold it through stalls, record its prediction
  task automatic send_op(input ubfu_pkg::cmd_t c,
                         input logic [ubfu_pkg::MANT_W-1:0] xm,
                         input logic signed [ubfu_pkg::EXP_W-1:0] xe,
                         input logic [ubfu_pkg::MANT_W-1:0] ym,
                         input logic signed [ubfu_pkg::EXP_W-1:0] ye);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_x_mantissa <= xm;
    in_x_exponent <= xe;
    in_y_mantissa <= ym;
    in_y_exponent <= ye;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bound_results_q.push_back(bound_op_result(c, xm, xe, ym, ye, overflow_checked));
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bound_results_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_check_overflow(input bit value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    overflow_checked = value;
  endtask

  // mixed: any command, a few reserved; otherwise only op
  task automatic run_random(input ubfu_pkg::cmd_t op, input bit mixed, input int count);
    ubfu_pkg::cmd_t                    c;
    logic [ubfu_pkg::MANT_W-1:0]       xm, ym;
    logic signed [ubfu_pkg::EXP_W-1:0] xe, ye, tmp;
    for (int i = 0; i < count; i++) begin
      set_idle_phase(i * 4 / count);
      c = op;
      if (mixed) begin
        if ($urandom_range(0, 99) < 4) c = ubfu_pkg::CMD_RSVD;
        else c = ubfu_pkg::cmd_t'($urandom_range(0, 2));
      end
      xm = rand_mantissa();
      ym = rand_mantissa();
      xe = rand_exponent();
      ye = rand_partner_exp(xe, c == ubfu_pkg::CMD_MUL);
      if ($urandom_range(0, 1)) begin
        tmp = xe; xe = ye; ye = tmp;
      end
      send_op(c, xm, xe, ym, ye);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_corners();
    set_idle_phase(3);
    // compare: zero x, zero y, equal, far-apart exponents
    send_op(ubfu_pkg::CMD_CMP, '0, '0, '0, '0);
    send_op(ubfu_pkg::CMD_CMP, '0, ubfu_pkg::E_MAX, ubfu_pkg::M_TOP, ubfu_pkg::E_MIN);
    send_op(ubfu_pkg::CMD_CMP, ubfu_pkg::M_TOP, 5, '0, 5);
    send_op(ubfu_pkg::CMD_CMP, 32'hC000_0000, 3, 32'hC000_0000, 3);
    send_op(ubfu_pkg::CMD_CMP, '1, ubfu_pkg::E_MIN, ubfu_pkg::M_TOP, ubfu_pkg::E_MAX);
    send_op(ubfu_pkg::CMD_CMP, ubfu_pkg::M_TOP, ubfu_pkg::E_MAX, '1, ubfu_pkg::E_MIN);
    send_op(ubfu_pkg::CMD_CMP, '1, -1, ubfu_pkg::M_TOP, 0);
    // add: carry, carry at max exponent, wide alignment, zeros
    send_op(ubfu_pkg::CMD_ADD, ubfu_pkg::M_TOP, 0, ubfu_pkg::M_TOP, 0);
    send_op(ubfu_pkg::CMD_ADD, ubfu_pkg::M_TOP, ubfu_pkg::E_MAX, '1, ubfu_pkg::E_MAX);
    send_op(ubfu_pkg::CMD_ADD, ubfu_pkg::M_TOP, 40, '1, 0);
    send_op(ubfu_pkg::CMD_ADD, '0, '0, '0, '0);
    send_op(ubfu_pkg::CMD_ADD, '0, ubfu_pkg::E_MIN, 32'hA000_0001, 7);
    send_op(ubfu_pkg::CMD_ADD, '1, ubfu_pkg::E_MIN, '1, ubfu_pkg::E_MAX);
    send_op(ubfu_pkg::CMD_ADD, 32'h8000_0001, 1, '1, 0);
    // multiply: zero, underflow, overflow, pass-through, normalize, min clamp
    send_op(ubfu_pkg::CMD_MUL, '0, 3, ubfu_pkg::M_TOP, 4);
    send_op(ubfu_pkg::CMD_MUL, ubfu_pkg::M_TOP, ubfu_pkg::E_MIN,
            ubfu_pkg::M_TOP, ubfu_pkg::E_MIN);
    send_op(ubfu_pkg::CMD_MUL, ubfu_pkg::M_TOP, ubfu_pkg::E_MAX, ubfu_pkg::M_TOP, 1);
    send_op(ubfu_pkg::CMD_MUL, 32'hFFFF_0001, 2, 32'h9000_0000, 3);
    send_op(ubfu_pkg::CMD_MUL, 32'hC000_0000, 2, '1, -3);
    send_op(ubfu_pkg::CMD_MUL, ubfu_pkg::M_TOP, 10, ubfu_pkg::M_TOP, -20);
    send_op(ubfu_pkg::CMD_MUL, ubfu_pkg::M_TOP, ubfu_pkg::E_MIN, ubfu_pkg::M_TOP, 0);
    send_op(ubfu_pkg::CMD_MUL, 32'h0000_0001, 0, 32'h0001_2345, 0);
    send_op(ubfu_pkg::CMD_MUL, 32'hB504_F334, 1, 32'hB504_F334, 1);
    // reserved command answers all zero
    send_op(ubfu_pkg::CMD_RSVD, '1, ubfu_pkg::E_MAX, '1, ubfu_pkg::E_MIN);
  endtask

  task automatic test_random_compare();
    run_random(ubfu_pkg::CMD_CMP, 1'b0, 250);
  endtask

  task automatic test_random_add();
    run_random(ubfu_pkg::CMD_ADD, 1'b0, 300);
  endtask

  task automatic test_random_multiply();
    run_random(ubfu_pkg::CMD_MUL, 1'b0, 300);
  endtask

  // overflow checking off: exponents wrap instead of flagging
  task automatic test_exponent_wrap();
    write_check_overflow(1'b0);
    set_idle_phase(0);
    send_op(ubfu_pkg::CMD_ADD, ubfu_pkg::M_TOP, ubfu_pkg::E_MAX,
            ubfu_pkg::M_TOP, ubfu_pkg::E_MAX);
    send_op(ubfu_pkg::CMD_MUL, ubfu_pkg::M_TOP, ubfu_pkg::E_MAX,
            ubfu_pkg::M_TOP, ubfu_pkg::E_MAX);
    send_op(ubfu_pkg::CMD_MUL, '1, ubfu_pkg::E_MAX, 32'hC000_0000, 5);
    send_op(ubfu_pkg::CMD_MUL, ubfu_pkg::M_TOP, ubfu_pkg::E_MIN, ubfu_pkg::M_TOP, -1);
    run_random(ubfu_pkg::CMD_CMP, 1'b1, 150);
    write_check_overflow(1'b1);
  endtask

  task automatic test_random_mixed();
    run_random(ubfu_pkg::CMD_CMP, 1'b1, 280);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    bound_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bound_results_q.size() == 0) begin
        $error("unexpected result beat: mantissa %h exponent %h",
               out_res_mantissa, out_res_exponent);
        fail_count++;
      end else begin
        want = bound_results_q.pop_front();
        if (out_res_mantissa !== want.mant) begin
          $error("res_mantissa: expected %h, got %h", want.mant, out_res_mantissa);
          fail_count++;
        end
        if (out_res_exponent !== want.expo) begin
          $error("res_exponent: expected %h, got %h", want.expo, out_res_exponent);
          fail_count++;
        end
        if (out_is_less !== want.less) begin
          $error("is_less: expected %b, got %b", want.less, out_is_less);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_compare();
    test_random_add();
    test_random_multiply();
    test_exponent_wrap();
    test_random_mixed();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: about 1300 beats finish well before this timeout even at heavy idling
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
